/* sv/sgi_pkg.sv */
// shared types, constants and span table for the shift-jis glyph index block
`timescale 1ns / 1ps

package sgi_pkg;

  localparam int unsigned CODE_W   = 16;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned OFS_W    = 17;
  localparam int unsigned GB_W     = 7;
  localparam int unsigned PROD_W   = IDX_W + GB_W;
  localparam int unsigned NUM_SPANS = 17;

  localparam int unsigned GLYPH_BYTES = 30;

  localparam logic [7:0] LEAD_MIN    = 8'h81;
  localparam logic [7:0] LEAD_MAX    = 8'h98;
  localparam logic [7:0] TRAIL_MIN   = 8'h40;
  localparam logic [7:0] TRAIL_GAP   = 8'h7f;
  localparam logic [7:0] TRAIL_MAX   = 8'hfc;
  localparam logic [7:0] ROW_CELLS   = 8'd94;
  localparam logic [5:0] SPAN_ROWS   = 6'd8;
  localparam logic [5:0] DENSE_FIRST = 6'd16;
  localparam logic [5:0] DENSE_LAST  = 6'd47;
  localparam logic [6:0] LAST_CELLS  = 7'd51;
  localparam logic [IDX_W-1:0] DENSE_BASE = 12'd524;

  localparam logic [CODE_W-1:0] PUNCT_LO = 16'h8140;
  localparam logic [CODE_W-1:0] PUNCT_HI = 16'h817c;
  localparam logic [CODE_W-1:0] HASH     = 16'h8194;
  localparam logic [CODE_W-1:0] DIGIT_LO = 16'h824f;
  localparam logic [CODE_W-1:0] DIGIT_HI = 16'h8258;
  localparam logic [CODE_W-1:0] UPPER_LO = 16'h8260;
  localparam logic [CODE_W-1:0] UPPER_HI = 16'h8279;
  localparam logic [CODE_W-1:0] LOWER_LO = 16'h8281;
  localparam logic [CODE_W-1:0] LOWER_HI = 16'h829a;

  localparam logic [IDX_W-1:0] HASH_IDX  = 12'd65;
  localparam logic [IDX_W-1:0] DIGIT_IDX = 12'd147;
  localparam logic [IDX_W-1:0] UPPER_IDX = 12'd157;
  localparam logic [IDX_W-1:0] LOWER_IDX = 12'd183;

  typedef struct packed {
    logic [5:0]       row;
    logic [6:0]       first;
    logic [6:0]       last;
    logic [IDX_W-1:0] base;
  } span_t;

  localparam span_t SPANS [NUM_SPANS] = '{
    '{6'd1, 7'd1,  7'd94, 12'd0},
    '{6'd2, 7'd1,  7'd14, 12'd94},
    '{6'd2, 7'd26, 7'd33, 12'd108},
    '{6'd2, 7'd42, 7'd48, 12'd116},
    '{6'd2, 7'd60, 7'd74, 12'd123},
    '{6'd2, 7'd82, 7'd89, 12'd138},
    '{6'd2, 7'd94, 7'd94, 12'd146},
    '{6'd3, 7'd16, 7'd25, 12'd147},
    '{6'd3, 7'd33, 7'd58, 12'd157},
    '{6'd3, 7'd65, 7'd90, 12'd183},
    '{6'd4, 7'd1,  7'd83, 12'd209},
    '{6'd5, 7'd1,  7'd86, 12'd292},
    '{6'd6, 7'd1,  7'd24, 12'd378},
    '{6'd6, 7'd33, 7'd56, 12'd402},
    '{6'd7, 7'd1,  7'd33, 12'd426},
    '{6'd7, 7'd49, 7'd81, 12'd459},
    '{6'd8, 7'd1,  7'd32, 12'd492}
  };

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [OFS_W-1:0] offset;
  } map_res_t;

endpackage

/* sv/sgi_map.sv */
// combinational code-to-glyph mapping for both rom layouts
`timescale 1ns / 1ps

module sgi_map import sgi_pkg::*; (
  input  logic              full_layout,
  input  logic [CODE_W-1:0] code,
  output map_res_t          res
);

  logic [7:0]        lead;
  logic [7:0]        trail;
  logic              bad;
  logic [4:0]        lead_off;
  logic [5:0]        row_a;
  logic [7:0]        cell0;
  logic [5:0]        row;
  logic [7:0]        cellm;
  logic [6:0]        kcell;
  logic              span_hit;
  logic [IDX_W-1:0]  span_idx;
  logic [4:0]        drow;
  logic [IDX_W-1:0]  dense_idx;
  logic              full_ok;
  logic [IDX_W-1:0]  full_idx;
  logic              alnum_ok;
  logic [IDX_W-1:0]  alnum_idx;
  logic              ok;
  logic [IDX_W-1:0]  idx;
  logic [PROD_W-1:0] prod;

  assign lead  = code[15:8];
  assign trail = code[7:0];
  assign bad   = (lead < LEAD_MIN) || (lead > LEAD_MAX) || (trail < TRAIL_MIN) ||
                 (trail == TRAIL_GAP) || (trail > TRAIL_MAX);

  // each lead byte covers two kuten rows
  assign lead_off = 5'(lead - LEAD_MIN);
  assign row_a    = {lead_off, 1'b1};
  assign cell0    = 8'(trail - TRAIL_MIN - {7'd0, (trail > TRAIL_GAP)});

  always_comb begin
    if (cell0 >= ROW_CELLS) begin
      row   = 6'(row_a + 6'd1);
      cellm = 8'(cell0 - ROW_CELLS);
    end else begin
      row   = row_a;
      cellm = cell0;
    end
  end

  assign kcell = 7'(cellm + 8'd1);

  // spans never overlap, so the matches can be or-ed together
  always_comb begin
    span_hit = 1'b0;
    span_idx = '0;
    for (int i = 0; i < NUM_SPANS; i++) begin
      if (SPANS[i].row == row && kcell >= SPANS[i].first && kcell <= SPANS[i].last) begin
        span_hit = 1'b1;
        span_idx = span_idx | 12'(SPANS[i].base + 12'(kcell - SPANS[i].first));
      end
    end
  end

  assign drow      = 5'(row - DENSE_FIRST);
  assign dense_idx = 12'(DENSE_BASE + 12'(drow) * 12'(ROW_CELLS) + 12'(kcell) - 12'd1);

  always_comb begin
    full_ok  = 1'b0;
    full_idx = '0;
    if (!bad) begin
      if (row <= SPAN_ROWS) begin
        full_ok  = span_hit;
        full_idx = span_idx;
      end else if (row >= DENSE_FIRST && row <= DENSE_LAST &&
                   !(row == DENSE_LAST && kcell > LAST_CELLS)) begin
        full_ok  = 1'b1;
        full_idx = dense_idx;
      end
    end
  end

  always_comb begin
    alnum_ok  = 1'b1;
    alnum_idx = '0;
    if (code inside {[PUNCT_LO:PUNCT_HI]}) begin
      alnum_idx = 12'(code - PUNCT_LO);
    end else if (code == HASH) begin
      alnum_idx = HASH_IDX;
    end else if (code inside {[DIGIT_LO:DIGIT_HI]}) begin
      alnum_idx = 12'(DIGIT_IDX + 12'(code - DIGIT_LO));
    end else if (code inside {[UPPER_LO:UPPER_HI]}) begin
      alnum_idx = 12'(UPPER_IDX + 12'(code - UPPER_LO));
    end else if (code inside {[LOWER_LO:LOWER_HI]}) begin
      alnum_idx = 12'(LOWER_IDX + 12'(code - LOWER_LO));
    end else begin
      alnum_ok  = 1'b0;
    end
  end

  assign ok   = full_layout ? full_ok : alnum_ok;
  assign idx  = ok ? (full_layout ? full_idx : alnum_idx) : '0;
  assign prod = PROD_W'(idx) * PROD_W'(GLYPH_BYTES);

  assign res.valid  = ok;
  assign res.index  = idx;
  assign res.offset = prod[OFS_W-1:0];

endmodule

/* sv/sjis_glyph_index.sv */
// top level: input register, glyph mapping and result register
// the input beat is registered in s1_code_r, mapped, and the result registered in res_r
// throughput: one beat per cycle while out_stall is low, set by the single mapping stage between registers
// in_stall rises only when both the input and result registers are held
// reset clears the layout register to the alphanumeric subset and empties both stages
`timescale 1ns / 1ps

module sjis_glyph_index import sgi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CODE_W-1:0] in_char_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_glyph_valid,
  output logic [IDX_W-1:0]  out_glyph_index,
  output logic [OFS_W-1:0]  out_glyph_byte_offset,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_full_kanji_layout
);

  logic              mode_r;
  logic              s1_valid_r;
  logic [CODE_W-1:0] s1_code_r;
  logic              out_valid_r;
  map_res_t          res_r;
  map_res_t          res;
  logic              adv_out;
  logic              adv_in;

  assign cfg_ready = 1'b1;
  assign adv_out   = !out_valid_r || !out_stall;
  assign adv_in    = !s1_valid_r || adv_out;
  assign in_stall  = !adv_in;

  sgi_map u_map (
    .full_layout (mode_r),
    .code        (s1_code_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_full_kanji_layout;
      end
      if (adv_in) begin
        s1_valid_r <= in_valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      s1_code_r <= in_char_code;
    end
    if (adv_out && s1_valid_r) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_glyph_valid       = res_r.valid;
  assign out_glyph_index       = res_r.index;
  assign out_glyph_byte_offset = res_r.offset;

endmodule

/* tb/sjis_glyph_checker.sv */
// checker for the shift-jis glyph index block: predicts each result beat and compares it
`timescale 1ns / 1ps

module sjis_glyph_checker import sgi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CODE_W-1:0] in_char_code,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_glyph_valid,
  input  logic [IDX_W-1:0]  out_glyph_index,
  input  logic [OFS_W-1:0]  out_glyph_byte_offset,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_full_kanji_layout,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                mapped
);

  // kuten rows 1..8 are sparse: one entry per contiguous run of cells
  localparam int KROW  [17] = '{1, 2, 2, 2, 2, 2, 2, 3, 3, 3, 4, 5, 6, 6, 7, 7, 8};
  localparam int KFROM [17] = '{1, 1, 26, 42, 60, 82, 94, 16, 33, 65, 1, 1, 1, 33, 1, 49, 1};
  localparam int KTO   [17] = '{94, 14, 33, 48, 74, 89, 94, 25, 58, 90, 83, 86, 24, 56,
                                33, 81, 32};
  localparam int KBASE [17] = '{0, 94, 108, 116, 123, 138, 146, 147, 157, 183, 209, 292,
                                378, 402, 426, 459, 492};

  map_res_t glyph_expected_q [$];
  logic     layout_full = 1'b0;
  int       errs = 0;
  int       n_checked = 0;
  int       n_mapped = 0;

  assign fail_count = errs;
  assign checked    = n_checked;
  assign mapped     = n_mapped;

  function automatic map_res_t glyph_lookup(input logic [CODE_W-1:0] code, input logic full);
    map_res_t r;
    int       lead;
    int       trail;
    int       row;
    int       kcell;
    int       idx;
    bit       hit;
    lead  = code[15:8];
    trail = code[7:0];
    hit   = 1'b0;
    idx   = 0;
    if (full) begin
      if (!(lead < 'h81 || lead > 'h98 || trail < 'h40 || trail == 'h7f || trail > 'hfc)) begin
        row   = (lead - 'h81) * 2 + 1;
        kcell = trail - 'h40 - ((trail > 'h7f) ? 1 : 0);
        // second half of the trail range belongs to the even row
        if (kcell >= 94) begin
          row   = row + 1;
          kcell = kcell - 94;
        end
        kcell = kcell + 1;
        if (row <= 8) begin
          for (int i = 0; i < 17; i++) begin
            if (!hit && KROW[i] == row && kcell >= KFROM[i] && kcell <= KTO[i]) begin
              hit = 1'b1;
              idx = KBASE[i] + kcell - KFROM[i];
            end
          end
        end else if (row >= 16 && row <= 47 && !(row == 47 && kcell > 51)) begin
          hit = 1'b1;
          idx = 524 + (row - 16) * 94 + kcell - 1;
        end
      end
    end else begin
      if (code >= 16'h8140 && code <= 16'h817c) begin
        hit = 1'b1;
        idx = code - 16'h8140;
      end else if (code == 16'h8194) begin
        hit = 1'b1;
        idx = 65;
      end else if (code >= 16'h824f && code <= 16'h8258) begin
        hit = 1'b1;
        idx = 147 + code - 16'h824f;
      end else if (code >= 16'h8260 && code <= 16'h8279) begin
        hit = 1'b1;
        idx = 157 + code - 16'h8260;
      end else if (code >= 16'h8281 && code <= 16'h829a) begin
        hit = 1'b1;
        idx = 183 + code - 16'h8281;
      end
    end
    r.valid  = hit;
    r.index  = hit ? idx[IDX_W-1:0] : '0;
    r.offset = hit ? OFS_W'(idx * GLYPH_BYTES) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    map_res_t want;
    if (!rst_n) begin
      glyph_expected_q.delete();
      layout_full = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) layout_full = cfg_full_kanji_layout;
      if (out_valid && !out_stall) begin
        n_checked++;
        if (glyph_expected_q.size() == 0) begin
          $error("result beat with nothing expected: glyph_index %0d", out_glyph_index);
          errs++;
        end else begin
          want = glyph_expected_q.pop_front();
          if (want.valid) n_mapped++;
          if (out_glyph_valid !== want.valid) begin
            $error("glyph_valid: expected %0d, got %0d", want.valid, out_glyph_valid);
            errs++;
          end
          if (out_glyph_index !== want.index) begin
            $error("glyph_index: expected %0d, got %0d", want.index, out_glyph_index);
            errs++;
          end
          if (out_glyph_byte_offset !== want.offset) begin
            $error("glyph_byte_offset: expected %0d, got %0d", want.offset,
                   out_glyph_byte_offset);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) glyph_expected_q.push_back(glyph_lookup(in_char_code, layout_full));
    end
    pending <= glyph_expected_q.size();
  end

endmodule

/* tb/tb_sjis_glyph_index.sv */
// testbench top for the shift-jis glyph index block: stimulus, layout writes and verdict
`timescale 1ns / 1ps

module tb_sjis_glyph_index;
  import sgi_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CODE_W-1:0] in_char_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_glyph_valid;
  logic [IDX_W-1:0]  out_glyph_index;
  logic [OFS_W-1:0]  out_glyph_byte_offset;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_full_kanji_layout = 1'b0;

  int fail_count;
  int pending;
  int checked;
  int mapped;

  int codes_sent = 0;
  int layout_writes = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  logic [CODE_W-1:0] alnum_codes [10] = '{
    16'h8140, 16'h817c, 16'h817d, 16'h8194, 16'h824f,
    16'h8258, 16'h8260, 16'h829a, 16'h0000, 16'hffff
  };
  // row edges, the trail gap, bad bytes and the end of row 47
  logic [CODE_W-1:0] kanji_codes [15] = '{
    16'h8140, 16'h817f, 16'h8180, 16'h819e, 16'h819f,
    16'h81fc, 16'h81fd, 16'h813f, 16'h8040, 16'h84be,
    16'h84bf, 16'h889e, 16'h889f, 16'h9872, 16'h9873
  };

  sjis_glyph_index dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_char_code          (in_char_code),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_glyph_valid       (out_glyph_valid),
    .out_glyph_index       (out_glyph_index),
    .out_glyph_byte_offset (out_glyph_byte_offset),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_full_kanji_layout (cfg_full_kanji_layout)
  );

  sjis_glyph_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_char_code          (in_char_code),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_glyph_valid       (out_glyph_valid),
    .out_glyph_index       (out_glyph_index),
    .out_glyph_byte_offset (out_glyph_byte_offset),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_full_kanji_layout (cfg_full_kanji_layout),
    .fail_count            (fail_count),
    .pending               (pending),
    .checked               (checked),
    .mapped                (mapped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CODE_W-1:0] pick_code(input logic full);
    int         r;
    logic [7:0] lead;
    logic [7:0] trail;
    r = $urandom_range(0, 99);
    if (r < 15) return CODE_W'($urandom);
    if (r < 30) begin
      lead  = 8'($urandom_range('h7f, 'h9a));
      trail = 8'($urandom);
    end else if (!full && r < 75) begin
      lead  = 8'($urandom_range('h81, 'h82));
      trail = 8'($urandom_range('h40, 'hfc));
    end else begin
      lead  = 8'($urandom_range('h81, 'h98));
      trail = 8'($urandom_range('h40, 'hfc));
    end
    return {lead, trail};
  endfunction

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      hold_left <= gap_len();
    end
  end

  task automatic send_code(input logic [CODE_W-1:0] code);
    int gap;
    in_valid     <= 1'b1;
    in_char_code <= code;
    @(posedge clk iff !in_stall);
    codes_sent++;
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_valid     <= 1'b0;
      in_char_code <= CODE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_layout(input logic full);
    drain();
    cfg_valid             <= 1'b1;
    cfg_full_kanji_layout <= full;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    layout_writes++;
  endtask

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset leaves the alphanumeric layout selected
    foreach (alnum_codes[i]) send_code(alnum_codes[i]);
    set_layout(1'b1);
    foreach (kanji_codes[i]) send_code(kanji_codes[i]);

    for (int p = 0; p < 6; p++) begin
      set_layout(p[0] == 1'b0);
      calm = (p == 2);
      repeat (150) send_code(pick_code(p[0] == 1'b0));
      calm = 1'b0;
    end

    drain();
    repeat (10) @(posedge clk);
    $display("%0d codes sent under %0d layout writes, both layouts and all idle patterns",
             codes_sent, layout_writes);
    $display("%0d result beats checked, %0d of them mapped to a glyph", checked, mapped);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
